// File: rtl/core/tli_pkg.sv
package tli_pkg;

    // store depths; program depth is taken as a power of two so that load addresses wrap
    localparam int PROG_DEPTH = 1024;
    localparam int TAPE_DEPTH = 1024;

    localparam int PA_W = $clog2(PROG_DEPTH);
    localparam int PC_W = $clog2(PROG_DEPTH + 1);
    localparam int TA_W = $clog2(TAPE_DEPTH);
    localparam int LA_W = 10;
    localparam int CH_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EXEC = 1'b1;

    localparam logic [CH_W-1:0] CH_INC   = 8'h2B;
    localparam logic [CH_W-1:0] CH_DEC   = 8'h2D;
    localparam logic [CH_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [CH_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [CH_W-1:0] CH_OUT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [CH_W-1:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic clear;
        logic load;
        logic finish;
        logic exec;
        logic scan_init;
        logic scan;
    } tli_cmd_t;

    typedef struct packed {
        logic halt;
        logic runnable;
        logic jump;
        logic scan_end;
        logic clr_last;
    } tli_status_t;

endpackage

// File: rtl/core/tli_ctrl.sv
module tli_ctrl
    import tli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        opcode,
    input  tli_status_t st,
    output tli_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_SCAN  = 4'b1000
    } tli_state_t;

    tli_state_t state_reg;
    tli_state_t state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        cmd.load  = 1'b1;
                        done_next = 1'b1;
                    end
                    else if (st.halt || !st.runnable)
                    begin
                        cmd.finish = 1'b1;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (st.jump)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_end)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// File: rtl/core/tli_datapath.sv
module tli_datapath
    import tli_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  tli_cmd_t        cmd,
    input  logic [LA_W-1:0] load_addr,
    input  logic [CH_W-1:0] load_char,
    input  logic            load_last,
    output tli_status_t     st,
    output logic            out_valid,
    output logic [CH_W-1:0] out_byte,
    output logic            halted,
    output logic            bracket_error
);

    logic [CH_W-1:0] prog_mem [PROG_DEPTH];
    logic [CH_W-1:0] tape_mem [TAPE_DEPTH];
    logic [CH_W-1:0] prog_rd_reg;
    logic [CH_W-1:0] tape_rd_reg;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [PC_W-1:0] len_reg, len_next;
    logic [TA_W-1:0] dp_reg, dp_next;
    logic            halt_reg, halt_next;
    logic            err_reg, err_next;
    logic [TA_W-1:0] clr_reg, clr_next;
    logic            out_valid_reg, out_valid_next;
    logic [CH_W-1:0] out_byte_reg, out_byte_next;
    logic [PC_W-1:0] q_reg, q_next;
    logic [PC_W-1:0] depth_reg, depth_next;
    logic            fwd_reg, fwd_next;

    logic [PA_W-1:0] ld_addr;
    logic [PC_W-1:0] rd_ptr;
    logic [PC_W-1:0] pc_inc;
    logic [PC_W-1:0] q_inc;
    logic            cell_zero;
    logic            is_open;
    logic            is_close;
    logic            scan_hit;
    logic            scan_err;
    logic            tape_we;
    logic [TA_W-1:0] tape_waddr;
    logic [CH_W-1:0] tape_wdata;

    assign ld_addr   = PA_W'(load_addr);
    assign pc_inc    = pc_reg + PC_W'(1);
    assign q_inc     = q_reg + PC_W'(1);
    assign cell_zero = (tape_rd_reg == '0);
    assign is_open   = (prog_rd_reg == CH_OPEN);
    assign is_close  = (prog_rd_reg == CH_CLOSE);

    // forward scan runs off the end of the program, backward scan off its start
    assign scan_hit = fwd_reg ? ((q_reg < len_reg) && is_close && (depth_reg == PC_W'(1)))
                              : (is_open && (depth_reg == PC_W'(1)));
    assign scan_err = fwd_reg ? (q_reg >= len_reg) : (!scan_hit && (q_reg == '0));

    // read data always lines up with q_reg while scanning
    always_comb
    begin
        if (cmd.scan)
        begin
            rd_ptr = fwd_reg ? q_inc : q_reg - PC_W'(1);
        end
        else if (cmd.scan_init)
        begin
            rd_ptr = is_open ? pc_inc : pc_reg - PC_W'(1);
        end
        else
        begin
            rd_ptr = pc_reg;
        end
    end

    assign tape_we    = cmd.clear
                     || (cmd.exec && ((prog_rd_reg == CH_INC) || (prog_rd_reg == CH_DEC)));
    assign tape_waddr = cmd.clear ? clr_reg : dp_reg;
    assign tape_wdata = cmd.clear ? '0
                      : (prog_rd_reg == CH_INC) ? tape_rd_reg + CH_W'(1)
                      : tape_rd_reg - CH_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prog_mem[ld_addr] <= load_char;
        end
        prog_rd_reg <= prog_mem[rd_ptr[PA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rd_reg <= tape_mem[dp_reg];
    end

    always_comb
    begin
        pc_next        = pc_reg;
        len_next       = len_reg;
        dp_next        = dp_reg;
        halt_next      = halt_reg;
        err_next       = err_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        q_next         = q_reg;
        depth_next     = depth_reg;
        fwd_next       = fwd_reg;

        if (cmd.clear)
        begin
            clr_next = clr_reg + TA_W'(1);
        end

        if (cmd.load)
        begin
            out_valid_next = 1'b0;
            out_byte_next  = '0;
            if (load_last)
            begin
                len_next  = PC_W'(ld_addr) + PC_W'(1);
                pc_next   = '0;
                dp_next   = '0;
                halt_next = 1'b0;
                err_next  = 1'b0;
            end
        end

        if (cmd.finish)
        begin
            halt_next      = 1'b1;
            out_valid_next = 1'b0;
            out_byte_next  = '0;
        end

        if (cmd.exec)
        begin
            out_valid_next = 1'b0;
            out_byte_next  = '0;
            pc_next        = pc_inc;
            halt_next      = (pc_inc >= len_reg);
            case (prog_rd_reg)
                CH_RIGHT:
                begin
                    dp_next = (dp_reg == TA_W'(TAPE_DEPTH - 1)) ? '0 : dp_reg + TA_W'(1);
                end
                CH_LEFT:
                begin
                    dp_next = (dp_reg == '0) ? TA_W'(TAPE_DEPTH - 1) : dp_reg - TA_W'(1);
                end
                CH_OUT:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = tape_rd_reg;
                end
                CH_CLOSE:
                begin
                    // taken close bracket at the first position has nothing to match
                    if (!cell_zero)
                    begin
                        pc_next   = pc_reg;
                        err_next  = 1'b1;
                        halt_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan_init)
        begin
            out_valid_next = 1'b0;
            out_byte_next  = '0;
            fwd_next       = is_open;
            q_next         = is_open ? pc_inc : pc_reg - PC_W'(1);
            depth_next     = PC_W'(1);
        end

        if (cmd.scan)
        begin
            if (scan_hit)
            begin
                pc_next   = q_inc;
                halt_next = (q_inc >= len_reg);
            end
            else if (scan_err)
            begin
                err_next  = 1'b1;
                halt_next = 1'b1;
            end
            else
            begin
                q_next = fwd_reg ? q_inc : q_reg - PC_W'(1);
                if ((fwd_reg && is_open) || (!fwd_reg && is_close))
                begin
                    depth_next = depth_reg + PC_W'(1);
                end
                else if ((fwd_reg && is_close) || (!fwd_reg && is_open))
                begin
                    depth_next = depth_reg - PC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            len_reg       <= '0;
            dp_reg        <= '0;
            halt_reg      <= 1'b1;
            err_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            len_reg       <= len_next;
            dp_reg        <= dp_next;
            halt_reg      <= halt_next;
            err_reg       <= err_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        q_reg        <= q_next;
        depth_reg    <= depth_next;
        fwd_reg      <= fwd_next;
    end

    assign st.halt     = halt_reg;
    assign st.runnable = (pc_reg < len_reg);
    assign st.jump     = (is_open && cell_zero) || (is_close && !cell_zero && (pc_reg != '0));
    assign st.scan_end = scan_hit || scan_err;
    assign st.clr_last = (clr_reg == TA_W'(TAPE_DEPTH - 1));

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign halted        = halt_reg;
    assign bracket_error = err_reg;

endmodule

// File: rtl/core/tape_language_interpreter_core_unit.sv
// channel   handshake       word
// -------   -------------   ---------------------------------------------
// command   start / busy    opcode, load_addr, load_char, load_last
// result    done (strobe)   out_valid, out_byte, halted, bracket_error
//
// a load, or a step while halted or at the program end, is answered from the idle state
// an ordinary step reads the program and tape stores, then executes in the EXEC state
// a taken bracket jump adds a scan of the program characters, one at a time,
// set by the single read port of the program store
// after reset the tape is cleared one cell a cycle with busy high, until every cell is zero
// done is a registered strobe raised after the last step of an item; the receiver cannot stall
module tape_language_interpreter_core_unit
    import tli_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            opcode,
    input  logic [LA_W-1:0] load_addr,
    input  logic [CH_W-1:0] load_char,
    input  logic            load_last,
    output logic            done,
    output logic            out_valid,
    output logic [CH_W-1:0] out_byte,
    output logic            halted,
    output logic            bracket_error
);

    tli_cmd_t    cmd;
    tli_status_t st;

    tli_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .st     (st),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tli_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .load_addr     (load_addr),
        .load_char     (load_char),
        .load_last     (load_last),
        .st            (st),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .halted        (halted),
        .bracket_error (bracket_error)
    );

endmodule
